FILE: hdl/counting_bit_filter_store_defines.svh
// Assertion macros for the counting bit filter store checker.
// Used only by the checker file; no other dependencies.
`ifndef COUNTING_BIT_FILTER_STORE_DEFINES_SVH
`define COUNTING_BIT_FILTER_STORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CBFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbfs check failed: %m");

// Next-cycle implication, disabled while reset is held.
`define CBFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbfs check failed: %m");

// Next-cycle implication that also holds across reset.
`define CBFS_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("cbfs check failed: %m");

`endif

FILE: hdl/cbfs_pkg.sv
// Shared types and constants for the counting bit filter store.
// No dependencies; used by every RTL file of the block except cbfs_ram.
`default_nettype none

package cbfs_pkg;

    localparam int unsigned MAX_BITS  = 1024;
    localparam int unsigned CNT_W     = 8;
    localparam int unsigned INDEX_W   = $clog2(MAX_BITS);
    localparam int unsigned ACTIVE_W  = $clog2(MAX_BITS + 1);
    localparam int unsigned WORD_W    = CNT_W + 1;   // presence bit over counter

    typedef enum logic [1:0] {
        REQ_INSERT = 2'd0,
        REQ_DELETE = 2'd1,
        REQ_TEST   = 2'd2,
        REQ_CLEAR  = 2'd3
    } req_t;

    typedef struct packed {
        req_t               req_type;
        logic [INDEX_W-1:0] bit_index;
    } in_item_t;

    typedef struct packed {
        logic             hit;
        logic [CNT_W-1:0] count_value;
        logic             ignored;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic op_load;    // latch the accepted request, issue the store read
        logic wipe_wr;    // write zero at the sweep address, advance sweep
        logic update;     // read-modify-write and produce the result
        logic emit;       // move a held result to the output register
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_is_clear;  // incoming request is a clear
        logic sweep_last;   // sweep counter at the final entry
        logic out_free;     // output register can load this cycle
    } ctrl_status_t;

endpackage

`default_nettype wire

FILE: hdl/counting_bit_filter_store.sv
// Top level of the counting bit filter store: controller plus datapath.
// Depends on cbfs_pkg, cbfs_ctrl, cbfs_datapath (and cbfs_ram below it).
//
// Bit-and-counter store of a counting Bloom filter. Each transaction on the
// s_ channel carries a request (insert, delete, test, clear) and a position
// index; each one yields exactly one result transaction on m_ (hit,
// count_value, ignored). Positions live in one 1024 x 9 RAM word each
// (presence bit over an 8-bit saturating counter). Insert, delete and test
// are a read-modify-write of that RAM: the read issues in the accept cycle,
// the update and write happen the next cycle, and a new request is taken
// only after that update; a result still waiting on m_ready does not block
// the next acceptance, but the following result then waits in res_reg, with
// s_ready low, until the output register is free. Clear writes zero over
// every entry, one per cycle, before its result is produced. After reset
// the same sweep runs over every entry with s_ready low; cfg writes are
// taken at any time (cfg_ready is always high) and are expected only while
// the block is idle. For insert, delete and test, indices at or above
// active_bits leave the store untouched and return ignored = 1.
`default_nettype none

module counting_bit_filter_store (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire cbfs_pkg::in_item_t            s_data,
    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output cbfs_pkg::out_item_t                m_data,
    // active_bits register write
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [cbfs_pkg::ACTIVE_W-1:0] cfg_data
);

    cbfs_pkg::ctrl_cmd_t    cmd;
    cbfs_pkg::ctrl_status_t status;

    // register port never stalls
    assign cfg_ready = 1'b1;

    cbfs_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    cbfs_datapath u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_data   (s_data),
        .cfg_wr   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire

FILE: hdl/cbfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module cbfs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cbfs_datapath.sv
// Datapath: request registers, active-size register, sweep counter, store RAM,
// update logic and output register. Depends on cbfs_pkg and cbfs_ram.
`default_nettype none

module cbfs_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire cbfs_pkg::ctrl_cmd_t           cmd,
    output cbfs_pkg::ctrl_status_t             status,
    input  wire cbfs_pkg::in_item_t            s_data,
    input  wire logic                          cfg_wr,
    input  wire logic [cbfs_pkg::ACTIVE_W-1:0] cfg_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output cbfs_pkg::out_item_t                m_data
);

    localparam logic [cbfs_pkg::CNT_W-1:0] CNT_MAX = {cbfs_pkg::CNT_W{1'b1}};
    localparam logic [cbfs_pkg::INDEX_W-1:0] LAST_ADDR =
        cbfs_pkg::INDEX_W'(cbfs_pkg::MAX_BITS - 1);

    logic [cbfs_pkg::ACTIVE_W-1:0] active_reg;
    cbfs_pkg::req_t                op_req_reg;
    logic [cbfs_pkg::INDEX_W-1:0]  op_idx_reg;
    logic                          op_oor_reg;
    logic [cbfs_pkg::INDEX_W-1:0]  sweep_reg;
    cbfs_pkg::out_item_t           res_reg;
    cbfs_pkg::out_item_t           m_data_reg;
    logic                          m_valid_reg;

    logic [cbfs_pkg::WORD_W-1:0]  rd_word;
    logic [cbfs_pkg::WORD_W-1:0]  wr_word;
    logic [cbfs_pkg::INDEX_W-1:0] wr_addr;
    logic                         wr_en;
    logic                         upd_wr;
    logic                         in_oor;
    logic [cbfs_pkg::CNT_W-1:0]   cur_cnt;
    logic                         cur_bit;
    logic [cbfs_pkg::CNT_W-1:0]   new_cnt;
    logic                         new_bit;
    cbfs_pkg::out_item_t          result;
    logic                         out_free;

    assign in_oor   = cbfs_pkg::ACTIVE_W'(s_data.bit_index) >= active_reg;
    assign out_free = !m_valid_reg || m_ready;

    assign status.in_is_clear = (s_data.req_type == cbfs_pkg::REQ_CLEAR);
    assign status.sweep_last  = (sweep_reg == LAST_ADDR);
    assign status.out_free    = out_free;

    assign cur_cnt = rd_word[cbfs_pkg::CNT_W-1:0];
    assign cur_bit = rd_word[cbfs_pkg::CNT_W];

    // counter update: saturating insert, delete ignored at zero
    always_comb begin
        new_cnt = cur_cnt;
        new_bit = cur_bit;
        upd_wr  = 1'b0;
        case (op_req_reg)
            cbfs_pkg::REQ_INSERT: begin
                new_bit = 1'b1;
                upd_wr  = 1'b1;
                if (cur_cnt != CNT_MAX) begin
                    new_cnt = cur_cnt + 1'b1;
                end
            end
            cbfs_pkg::REQ_DELETE: begin
                if (cur_cnt != '0) begin
                    new_cnt = cur_cnt - 1'b1;
                    upd_wr  = 1'b1;
                    if (new_cnt == '0) begin
                        new_bit = 1'b0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        result = '0;
        if (op_req_reg == cbfs_pkg::REQ_CLEAR) begin
            result = '0;
        end else if (op_oor_reg) begin
            result.ignored = 1'b1;
        end else begin
            result.hit         = new_bit;
            result.count_value = new_cnt;
        end
    end

    assign wr_en   = cmd.wipe_wr ||
                     (cmd.update && upd_wr && !op_oor_reg &&
                      (op_req_reg != cbfs_pkg::REQ_CLEAR));
    assign wr_addr = cmd.wipe_wr ? sweep_reg : op_idx_reg;
    assign wr_word = cmd.wipe_wr ? '0 : {new_bit, new_cnt};

    cbfs_ram #(
        .WIDTH (cbfs_pkg::WORD_W),
        .DEPTH (cbfs_pkg::MAX_BITS)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_word),
        .rd_en   (cmd.op_load),
        .rd_addr (s_data.bit_index),
        .rd_data (rd_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= cbfs_pkg::ACTIVE_W'(cbfs_pkg::MAX_BITS);
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr) begin
                active_reg <= cfg_data;
            end
            if (cmd.wipe_wr) begin
                sweep_reg <= status.sweep_last ? '0 : sweep_reg + 1'b1;
            end
            if ((cmd.update || cmd.emit) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op_load) begin
            op_req_reg <= s_data.req_type;
            op_idx_reg <= s_data.bit_index;
            op_oor_reg <= in_oor;
        end
        if (cmd.update) begin
            res_reg <= result;
        end
        if ((cmd.update || cmd.emit) && out_free) begin
            m_data_reg <= cmd.update ? result : res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

FILE: hdl/cbfs_ctrl.sv
// Controller: sequences reset wipe, clear sweep, read-modify-write and result
// hand-off. Depends on cbfs_pkg.
`default_nettype none

module cbfs_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire cbfs_pkg::ctrl_status_t status,
    output cbfs_pkg::ctrl_cmd_t         cmd
);

    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_WIPE   = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.op_load = accept;
        case (state_reg)
            ST_INIT: begin
                cmd.wipe_wr = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    state_next = status.in_is_clear ? ST_WIPE : ST_UPDATE;
                end
            end
            ST_WIPE: begin
                cmd.wipe_wr = 1'b1;
                if (status.sweep_last) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                state_next = status.out_free ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT: begin
                cmd.emit = 1'b1;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/cbfs_checker.sv
// Port-level checker for counting_bit_filter_store, bound to the top level.
// Depends on cbfs_pkg and counting_bit_filter_store_defines.svh.
`default_nettype none

`include "counting_bit_filter_store_defines.svh"

module cbfs_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire cbfs_pkg::out_item_t m_data
);

    // a stalled result holds
    `CBFS_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // one request at a time: no back-to-back acceptance
    `CBFS_ASSERT_NEXT(a_no_b2b, aclk, aresetn, s_valid && s_ready, !s_ready)

    // the wipe after reset keeps the request channel closed
    `CBFS_ASSERT_ALWAYS_NEXT(a_reset_wipe, aclk, !aresetn, !s_ready)

    // presence bit tracks a nonzero counter
    `CBFS_ASSERT_NOW(a_hit_count, aclk, aresetn, m_valid, m_data.hit == (m_data.count_value != '0))

endmodule

bind counting_bit_filter_store cbfs_checker u_cbfs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire
